@@ rtl/core/sfc_pkg.sv @@
// ----------------------------------------------------------------------------
// sfc_pkg: shared types and constants of the sensor frame conditioner
// Operation codes, controller states, command/status bundles, register
// indexes, fixed conversion constants and the temperature curve.
// ----------------------------------------------------------------------------
package sfc_pkg;

   localparam int ADC_W = 12;
   localparam int NUM_W = 28;
   localparam int DEN_W = 12;
   localparam int DIV_CYCLES = NUM_W / 2;
   localparam int TEMP_CURVE_LEN = 21;

   localparam logic [11:0] ADC_MAX = 12'd4095;
   localparam int ADC_SPAN = 4096;
   localparam logic [14:0] MV_FULL = 15'd3300;
   localparam logic [14:0] MA_PER_A = 15'd1000;

   localparam logic signed [15:0] PRESS_MIN = 16'sd0;
   localparam logic signed [15:0] PRESS_MAX = 16'sd500;
   localparam logic signed [15:0] OXY_MIN = 16'sd0;
   localparam logic signed [15:0] OXY_MAX = 16'sd1000;
   localparam logic signed [15:0] FLOW_MIN = 16'sd0;
   localparam logic signed [15:0] FLOW_MAX = 16'sd150;
   localparam logic signed [15:0] TMOT_MIN = -16'sd200;
   localparam logic signed [15:0] TMOT_MAX = 16'sd1200;
   localparam logic signed [15:0] TAMB_MIN = -16'sd200;
   localparam logic signed [15:0] TAMB_MAX = 16'sd600;
   localparam logic signed [15:0] CUR_MIN = 16'sd0;
   localparam logic signed [15:0] CUR_MAX = 16'sd25000;

   localparam logic [3:0] CSR_PRESSURE_ADC_LOW = 4'd0;
   localparam logic [3:0] CSR_PRESSURE_ADC_HIGH = 4'd1;
   localparam logic [3:0] CSR_PRESSURE_FULL_SCALE = 4'd2;
   localparam logic [3:0] CSR_OXYGEN_ADC_HIGH = 4'd3;
   localparam logic [3:0] CSR_OXYGEN_FULL_SCALE = 4'd4;
   localparam logic [3:0] CSR_FLOW_ADC_HIGH = 4'd5;
   localparam logic [3:0] CSR_FLOW_FULL_SCALE = 4'd6;
   localparam logic [3:0] CSR_CURRENT_ZERO_OFFSET = 4'd7;

   typedef enum logic [3:0] {
      OP_P_TANK, OP_P_BED_A, OP_P_BED_B, OP_OXY, OP_FLOW, OP_TEMP_MOT,
      OP_TEMP_AMB, OP_MV, OP_CUR, OP_SM_TANK, OP_SM_OXY, OP_SM_FLOW
   } op_type;

   localparam op_type OP_LAST = OP_SM_FLOW;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SETUP, ST_DIV, ST_STORE, ST_FINISH
   } state_type;

   typedef struct packed {
      logic   load;
      logic   setup;
      logic   store;
      logic   publish;
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic bypass;
      logic div_done;
   } sts_type;

   function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
      logic signed [15:0] r;
      if (v > 32'sd32767) r = 16'sd32767;
      else if (v < -32'sd32768) r = -16'sd32768;
      else r = v[15:0];
      return r;
   endfunction

   function automatic logic signed [11:0] temp_curve(input logic [4:0] idx);
      logic signed [11:0] r;
      case (idx)
         5'd0: r = 12'sd1200;
         5'd1: r = 12'sd1100;
         5'd2: r = 12'sd1000;
         5'd3: r = 12'sd900;
         5'd4: r = 12'sd800;
         5'd5: r = 12'sd700;
         5'd6: r = 12'sd600;
         5'd7: r = 12'sd550;
         5'd8: r = 12'sd500;
         5'd9: r = 12'sd450;
         5'd10: r = 12'sd400;
         5'd11: r = 12'sd350;
         5'd12: r = 12'sd300;
         5'd13: r = 12'sd250;
         5'd14: r = 12'sd200;
         5'd15: r = 12'sd150;
         5'd16: r = 12'sd100;
         5'd17: r = 12'sd50;
         5'd18: r = 12'sd0;
         5'd19: r = -12'sd50;
         5'd20: r = -12'sd100;
         default: r = -12'sd100;
      endcase
      return r;
   endfunction

endpackage

@@ rtl/core/sfc_div.sv @@
// ----------------------------------------------------------------------------
// sfc_div: shared unsigned divider
// Restoring division, two quotient bits per cycle; done holds until the
// next start.
// ----------------------------------------------------------------------------
module sfc_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [sfc_pkg::NUM_W-1:0]  num,
   input  logic [sfc_pkg::DEN_W-1:0]  den,
   output logic [sfc_pkg::NUM_W-1:0]  quo,
   output logic                       done
);

   logic [sfc_pkg::NUM_W-1:0] work_ff, work_in;
   logic [sfc_pkg::DEN_W-1:0] rem_ff, rem_in;
   logic [sfc_pkg::DEN_W-1:0] den_ff;
   logic [3:0]                cnt_ff, cnt_in;
   logic                      done_ff, done_in;

   always_comb begin
      logic [sfc_pkg::DEN_W:0]   sh;
      logic [sfc_pkg::DEN_W-1:0] r;
      logic [sfc_pkg::NUM_W-1:0] w;
      r = rem_ff;
      w = work_ff;
      for (int i = 0; i < 2; i++) begin
         sh = {r, w[sfc_pkg::NUM_W-1]};
         w = {w[sfc_pkg::NUM_W-2:0], 1'b0};
         if (sh >= {1'b0, den_ff}) begin
            r = sh[sfc_pkg::DEN_W-1:0] - den_ff;
            w[0] = 1'b1;
         end else begin
            r = sh[sfc_pkg::DEN_W-1:0];
         end
      end
      work_in = work_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      done_in = done_ff;
      if (start) begin
         work_in = num;
         rem_in = '0;
         cnt_in = 4'(sfc_pkg::DIV_CYCLES);
         done_in = 1'b0;
      end else if (cnt_ff != 4'd0) begin
         work_in = w;
         rem_in = r;
         cnt_in = cnt_ff - 4'd1;
         done_in = (cnt_ff == 4'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         done_ff <= done_in;
      end
      work_ff <= work_in;
      rem_ff <= rem_in;
      if (start) den_ff <= den;
   end

   assign quo = work_ff;
   assign done = done_ff;

endmodule

@@ rtl/core/sfc_ctrl.sv @@
// ----------------------------------------------------------------------------
// sfc_ctrl: frame sequencer
// Walks the conversion operations in order and owns both handshakes.
// ----------------------------------------------------------------------------
module sfc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  sfc_pkg::sts_type  sts,
   output sfc_pkg::cmd_type  cmd
);

   sfc_pkg::state_type state_ff, state_in;
   sfc_pkg::op_type    op_ff, op_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      case (state_ff)
         sfc_pkg::ST_IDLE: begin
            op_in = sfc_pkg::OP_P_TANK;
            if (req_valid) state_in = sfc_pkg::ST_SETUP;
         end
         sfc_pkg::ST_SETUP: begin
            state_in = sts.bypass ? sfc_pkg::ST_STORE : sfc_pkg::ST_DIV;
         end
         sfc_pkg::ST_DIV: begin
            if (sts.div_done) state_in = sfc_pkg::ST_STORE;
         end
         sfc_pkg::ST_STORE: begin
            if (op_ff == sfc_pkg::OP_LAST) begin
               state_in = sfc_pkg::ST_FINISH;
            end else begin
               state_in = sfc_pkg::ST_SETUP;
               op_in = sfc_pkg::op_type'(4'(op_ff + 4'd1));
            end
         end
         sfc_pkg::ST_FINISH: begin
            if (out_free) state_in = sfc_pkg::ST_IDLE;
         end
         default: state_in = sfc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.load = (state_ff == sfc_pkg::ST_IDLE) && req_valid;
      cmd.setup = (state_ff == sfc_pkg::ST_SETUP);
      cmd.store = (state_ff == sfc_pkg::ST_STORE);
      cmd.publish = (state_ff == sfc_pkg::ST_FINISH) && out_free;
      cmd.op = op_ff;
      req_ready = (state_ff == sfc_pkg::ST_IDLE);
      if (cmd.publish) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sfc_pkg::ST_IDLE;
         op_ff <= sfc_pkg::OP_P_TANK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/core/sfc_datapath.sv @@
// ----------------------------------------------------------------------------
// sfc_datapath: conversion datapath
// Configuration registers, frame capture, operand setup with one multiplier,
// the shared divider, result registers, filters and the output register.
// ----------------------------------------------------------------------------
module sfc_datapath #(
   parameter int TEMP_TABLE_ENTRIES = 21,
   parameter int SMOOTHING_DIVISOR = 16,
   parameter int CURRENT_SENSITIVITY_MV = 185
) (
   input  logic                clock,
   input  logic                reset,
   input  sfc_pkg::cmd_type    cmd,
   output sfc_pkg::sts_type    sts,
   input  logic                csr_valid,
   input  logic [3:0]          csr_index,
   input  logic [15:0]         csr_data,
   input  logic [11:0]         req_raw_tank_pressure,
   input  logic [11:0]         req_raw_bed_a_pressure,
   input  logic [11:0]         req_raw_bed_b_pressure,
   input  logic [11:0]         req_raw_oxygen,
   input  logic [11:0]         req_raw_flow,
   input  logic [11:0]         req_raw_motor_temp,
   input  logic [11:0]         req_raw_ambient_temp,
   input  logic [11:0]         req_raw_drive_current,
   input  logic [31:0]         req_sample_time,
   output logic signed [15:0]  rsp_tank_pressure,
   output logic signed [15:0]  rsp_bed_a_pressure,
   output logic signed [15:0]  rsp_bed_b_pressure,
   output logic signed [15:0]  rsp_oxygen_purity,
   output logic signed [15:0]  rsp_flow_dlpm,
   output logic signed [11:0]  rsp_motor_temp,
   output logic signed [11:0]  rsp_ambient_temp,
   output logic signed [15:0]  rsp_drive_current,
   output logic [31:0]         rsp_frame_time,
   output logic [7:0]          rsp_valid_mask
);

   localparam int TEMP_STEP = sfc_pkg::ADC_SPAN / TEMP_TABLE_ENTRIES;
   localparam int IDX_MAX = (TEMP_TABLE_ENTRIES - 2 < sfc_pkg::TEMP_CURVE_LEN - 1) ?
                            TEMP_TABLE_ENTRIES - 2 : sfc_pkg::TEMP_CURVE_LEN - 1;

   // configuration
   logic [11:0] p_low_ff, p_high_ff, o_high_ff, f_high_ff, cur_off_ff;
   logic [14:0] p_fs_ff, o_fs_ff, f_fs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_low_ff <= 12'd0;
         p_high_ff <= 12'd4095;
         p_fs_ff <= 15'd500;
         o_high_ff <= 12'd4095;
         o_fs_ff <= 15'd1000;
         f_high_ff <= 12'd4095;
         f_fs_ff <= 15'd150;
         cur_off_ff <= 12'd2500;
      end else if (csr_valid) begin
         case (csr_index)
            sfc_pkg::CSR_PRESSURE_ADC_LOW: p_low_ff <= csr_data[11:0];
            sfc_pkg::CSR_PRESSURE_ADC_HIGH: p_high_ff <= csr_data[11:0];
            sfc_pkg::CSR_PRESSURE_FULL_SCALE: p_fs_ff <= csr_data[14:0];
            sfc_pkg::CSR_OXYGEN_ADC_HIGH: o_high_ff <= csr_data[11:0];
            sfc_pkg::CSR_OXYGEN_FULL_SCALE: o_fs_ff <= csr_data[14:0];
            sfc_pkg::CSR_FLOW_ADC_HIGH: f_high_ff <= csr_data[11:0];
            sfc_pkg::CSR_FLOW_FULL_SCALE: f_fs_ff <= csr_data[14:0];
            sfc_pkg::CSR_CURRENT_ZERO_OFFSET: cur_off_ff <= csr_data[11:0];
            default: ;
         endcase
      end
   end

   // frame capture and intermediate results
   logic [11:0]        raw_ff [0:7];
   logic [31:0]        time_ff;
   logic signed [15:0] press_ff [0:2];
   logic signed [15:0] oxy_ff, flow_ff, cur_ff;
   logic signed [11:0] tmot_ff, tamb_ff;
   logic [11:0]        mv_ff;
   logic signed [15:0] acc_ff [0:2];

   // operand setup
   logic [11:0]               adc;
   logic [12:0]               mul_a;
   logic [14:0]               mul_b;
   logic [sfc_pkg::NUM_W-1:0] product, num_direct, div_num;
   logic [sfc_pkg::DEN_W-1:0] den;
   logic                      use_mul, su_byp, su_neg;
   logic signed [15:0]        su_byp_val;
   logic signed [12:0]        cur_d;
   logic signed [16:0]        sm_d;
   logic signed [15:0]        sm_x, sm_s;
   logic [1:0]                sm_idx;

   always_comb begin
      case (cmd.op)
         sfc_pkg::OP_P_TANK: adc = raw_ff[0];
         sfc_pkg::OP_P_BED_A: adc = raw_ff[1];
         sfc_pkg::OP_P_BED_B: adc = raw_ff[2];
         sfc_pkg::OP_OXY: adc = raw_ff[3];
         sfc_pkg::OP_FLOW: adc = raw_ff[4];
         sfc_pkg::OP_TEMP_MOT: adc = raw_ff[5];
         sfc_pkg::OP_TEMP_AMB: adc = raw_ff[6];
         sfc_pkg::OP_MV: adc = raw_ff[7];
         default: adc = '0;
      endcase
      case (cmd.op)
         sfc_pkg::OP_SM_OXY: begin
            sm_idx = 2'd1;
            sm_x = oxy_ff;
         end
         sfc_pkg::OP_SM_FLOW: begin
            sm_idx = 2'd2;
            sm_x = flow_ff;
         end
         default: begin
            sm_idx = 2'd0;
            sm_x = press_ff[0];
         end
      endcase
   end

   assign sm_s = acc_ff[sm_idx];
   assign sm_d = 17'(sm_x) - 17'(sm_s);
   assign cur_d = $signed({1'b0, mv_ff}) - $signed({1'b0, cur_off_ff});

   always_comb begin
      su_byp = 1'b0;
      su_byp_val = '0;
      su_neg = 1'b0;
      use_mul = 1'b1;
      mul_a = '0;
      mul_b = '0;
      num_direct = '0;
      den = '0;
      case (cmd.op)
         sfc_pkg::OP_P_TANK, sfc_pkg::OP_P_BED_A, sfc_pkg::OP_P_BED_B: begin
            if (adc <= p_low_ff) begin
               su_byp = 1'b1;
            end else if (adc >= p_high_ff) begin
               su_byp = 1'b1;
               su_byp_val = $signed({1'b0, p_fs_ff});
            end else begin
               mul_a = {1'b0, adc - p_low_ff};
               mul_b = p_fs_ff;
               den = p_high_ff - p_low_ff;
            end
         end
         sfc_pkg::OP_OXY: begin
            if (adc >= o_high_ff) begin
               su_byp = 1'b1;
               su_byp_val = $signed({1'b0, o_fs_ff});
            end else begin
               mul_a = {1'b0, adc};
               mul_b = o_fs_ff;
               den = o_high_ff;
            end
         end
         sfc_pkg::OP_FLOW: begin
            if (f_high_ff == 12'd0) begin
               su_byp = 1'b1;
               su_byp_val = $signed({1'b0, f_fs_ff});
            end else begin
               mul_a = {1'b0, adc};
               mul_b = f_fs_ff;
               den = f_high_ff;
            end
         end
         sfc_pkg::OP_TEMP_MOT, sfc_pkg::OP_TEMP_AMB: begin
            mul_a = {1'b0, adc};
            mul_b = 15'd1;
            den = sfc_pkg::DEN_W'(TEMP_STEP);
         end
         sfc_pkg::OP_MV: begin
            mul_a = {1'b0, adc};
            mul_b = sfc_pkg::MV_FULL;
            den = sfc_pkg::ADC_MAX;
         end
         sfc_pkg::OP_CUR: begin
            su_neg = cur_d[12];
            mul_a = su_neg ? 13'(-cur_d) : 13'(cur_d);
            mul_b = sfc_pkg::MA_PER_A;
            den = sfc_pkg::DEN_W'(CURRENT_SENSITIVITY_MV);
         end
         sfc_pkg::OP_SM_TANK, sfc_pkg::OP_SM_OXY, sfc_pkg::OP_SM_FLOW: begin
            use_mul = 1'b0;
            su_neg = sm_d[16];
            num_direct = sfc_pkg::NUM_W'(su_neg ? 17'(-sm_d) : 17'(sm_d));
            den = sfc_pkg::DEN_W'(SMOOTHING_DIVISOR);
         end
         default: ;
      endcase
   end

   assign product = mul_a * mul_b;
   assign div_num = use_mul ? product : num_direct;
   assign sts.bypass = su_byp;

   logic [sfc_pkg::NUM_W-1:0] quo;
   logic                      div_done;

   sfc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.setup && !su_byp),
      .num   (div_num),
      .den   (den),
      .quo   (quo),
      .done  (div_done)
   );

   assign sts.div_done = div_done;

   logic               byp_ff, neg_ff;
   logic signed [15:0] byp_val_ff;

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         byp_ff <= su_byp;
         byp_val_ff <= su_byp_val;
         neg_ff <= su_neg;
      end
   end

   // result store
   logic signed [sfc_pkg::NUM_W:0] qs;
   logic signed [15:0]             q_val, flow_q;
   logic [4:0]                     t_idx;

   assign qs = neg_ff ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
   assign q_val = byp_ff ? byp_val_ff : $signed(quo[15:0]);
   assign flow_q = byp_ff ? byp_val_ff :
                   (quo > sfc_pkg::NUM_W'(32767)) ? 16'sd32767 : $signed(quo[15:0]);
   assign t_idx = (quo > sfc_pkg::NUM_W'(IDX_MAX)) ? 5'(IDX_MAX) : quo[4:0];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         raw_ff[0] <= req_raw_tank_pressure;
         raw_ff[1] <= req_raw_bed_a_pressure;
         raw_ff[2] <= req_raw_bed_b_pressure;
         raw_ff[3] <= req_raw_oxygen;
         raw_ff[4] <= req_raw_flow;
         raw_ff[5] <= req_raw_motor_temp;
         raw_ff[6] <= req_raw_ambient_temp;
         raw_ff[7] <= req_raw_drive_current;
         time_ff <= req_sample_time;
      end
      if (cmd.store) begin
         case (cmd.op)
            sfc_pkg::OP_P_TANK: press_ff[0] <= q_val;
            sfc_pkg::OP_P_BED_A: press_ff[1] <= q_val;
            sfc_pkg::OP_P_BED_B: press_ff[2] <= q_val;
            sfc_pkg::OP_OXY: oxy_ff <= q_val;
            sfc_pkg::OP_FLOW: flow_ff <= flow_q;
            sfc_pkg::OP_TEMP_MOT: tmot_ff <= sfc_pkg::temp_curve(t_idx);
            sfc_pkg::OP_TEMP_AMB: tamb_ff <= sfc_pkg::temp_curve(t_idx);
            sfc_pkg::OP_MV: mv_ff <= quo[11:0];
            sfc_pkg::OP_CUR: cur_ff <= sfc_pkg::sat16(32'(qs));
            default: ;
         endcase
      end
   end

   // filter accumulators
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) acc_ff[i] <= '0;
      end else if (cmd.store && (cmd.op == sfc_pkg::OP_SM_TANK ||
                                 cmd.op == sfc_pkg::OP_SM_OXY ||
                                 cmd.op == sfc_pkg::OP_SM_FLOW)) begin
         acc_ff[sm_idx] <= sfc_pkg::sat16(32'(sm_s) + 32'(qs));
      end
   end

   // output register
   logic [7:0] mask;

   always_comb begin
      mask[0] = acc_ff[0] >= sfc_pkg::PRESS_MIN && acc_ff[0] <= sfc_pkg::PRESS_MAX;
      mask[1] = press_ff[1] >= sfc_pkg::PRESS_MIN && press_ff[1] <= sfc_pkg::PRESS_MAX;
      mask[2] = press_ff[2] >= sfc_pkg::PRESS_MIN && press_ff[2] <= sfc_pkg::PRESS_MAX;
      mask[3] = acc_ff[1] >= sfc_pkg::OXY_MIN && acc_ff[1] <= sfc_pkg::OXY_MAX;
      mask[4] = acc_ff[2] >= sfc_pkg::FLOW_MIN && acc_ff[2] <= sfc_pkg::FLOW_MAX;
      mask[5] = 16'(tmot_ff) >= sfc_pkg::TMOT_MIN && 16'(tmot_ff) <= sfc_pkg::TMOT_MAX;
      mask[6] = 16'(tamb_ff) >= sfc_pkg::TAMB_MIN && 16'(tamb_ff) <= sfc_pkg::TAMB_MAX;
      mask[7] = cur_ff >= sfc_pkg::CUR_MIN && cur_ff <= sfc_pkg::CUR_MAX;
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_tank_pressure <= acc_ff[0];
         rsp_bed_a_pressure <= press_ff[1];
         rsp_bed_b_pressure <= press_ff[2];
         rsp_oxygen_purity <= acc_ff[1];
         rsp_flow_dlpm <= acc_ff[2];
         rsp_motor_temp <= tmot_ff;
         rsp_ambient_temp <= tamb_ff;
         rsp_drive_current <= cur_ff;
         rsp_frame_time <= time_ff;
         rsp_valid_mask <= mask;
      end
   end

endmodule

@@ rtl/core/sensor_frame_conditioner.sv @@
// ----------------------------------------------------------------------------
// sensor_frame_conditioner: sensor frame to engineering units
// Top level: sequencer, conversion datapath and the assertions.
// ----------------------------------------------------------------------------
// One frame of eight ADC readings is taken per transaction and converted in
// twelve steps through a single shared divider that retires two quotient
// bits per cycle: three pressures, oxygen, flow, two temperature lookups,
// current millivolts, motor current and three filter updates. Each step
// passes through a setup state, the divide state until the divider is done
// and a store state, or only setup and store when a clamp or a zero flow
// span decides the value. A new frame is accepted once the previous one has
// been converted and moved into the output register, even while its result
// still waits there. Configuration writes are always taken and must only be
// issued while the block is idle.
// ----------------------------------------------------------------------------
module sensor_frame_conditioner #(
   parameter int TEMP_TABLE_ENTRIES = 21,
   parameter int SMOOTHING_DIVISOR = 16,
   parameter int CURRENT_SENSITIVITY_MV = 185
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [3:0]          csr_index,
   input  logic [15:0]         csr_data,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [11:0]         req_raw_tank_pressure,
   input  logic [11:0]         req_raw_bed_a_pressure,
   input  logic [11:0]         req_raw_bed_b_pressure,
   input  logic [11:0]         req_raw_oxygen,
   input  logic [11:0]         req_raw_flow,
   input  logic [11:0]         req_raw_motor_temp,
   input  logic [11:0]         req_raw_ambient_temp,
   input  logic [11:0]         req_raw_drive_current,
   input  logic [31:0]         req_sample_time,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [15:0]  rsp_tank_pressure,
   output logic signed [15:0]  rsp_bed_a_pressure,
   output logic signed [15:0]  rsp_bed_b_pressure,
   output logic signed [15:0]  rsp_oxygen_purity,
   output logic signed [15:0]  rsp_flow_dlpm,
   output logic signed [11:0]  rsp_motor_temp,
   output logic signed [11:0]  rsp_ambient_temp,
   output logic signed [15:0]  rsp_drive_current,
   output logic [31:0]         rsp_frame_time,
   output logic [7:0]          rsp_valid_mask
);

   sfc_pkg::cmd_type cmd;
   sfc_pkg::sts_type sts;

   // register writes take effect in the following cycle, never stall
   assign csr_ready = 1'b1;

   sfc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   sfc_datapath #(
      .TEMP_TABLE_ENTRIES     (TEMP_TABLE_ENTRIES),
      .SMOOTHING_DIVISOR      (SMOOTHING_DIVISOR),
      .CURRENT_SENSITIVITY_MV (CURRENT_SENSITIVITY_MV)
   ) u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .sts                    (sts),
      .csr_valid              (csr_valid),
      .csr_index              (csr_index),
      .csr_data               (csr_data),
      .req_raw_tank_pressure  (req_raw_tank_pressure),
      .req_raw_bed_a_pressure (req_raw_bed_a_pressure),
      .req_raw_bed_b_pressure (req_raw_bed_b_pressure),
      .req_raw_oxygen         (req_raw_oxygen),
      .req_raw_flow           (req_raw_flow),
      .req_raw_motor_temp     (req_raw_motor_temp),
      .req_raw_ambient_temp   (req_raw_ambient_temp),
      .req_raw_drive_current  (req_raw_drive_current),
      .req_sample_time        (req_sample_time),
      .rsp_tank_pressure      (rsp_tank_pressure),
      .rsp_bed_a_pressure     (rsp_bed_a_pressure),
      .rsp_bed_b_pressure     (rsp_bed_b_pressure),
      .rsp_oxygen_purity      (rsp_oxygen_purity),
      .rsp_flow_dlpm          (rsp_flow_dlpm),
      .rsp_motor_temp         (rsp_motor_temp),
      .rsp_ambient_temp       (rsp_ambient_temp),
      .rsp_drive_current      (rsp_drive_current),
      .rsp_frame_time         (rsp_frame_time),
      .rsp_valid_mask         (rsp_valid_mask)
   );

   // an accepted frame goes straight to its first setup step
   a_load_setup: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> cmd.setup)
      else $error("frame accepted without starting conversion");

   // never overwrite a result that is still waiting
   a_publish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> !rsp_valid || rsp_ready)
      else $error("output register overwritten before transaction");

   // a store follows either a bypassed setup or a finished division
   a_store_src: assert property (@(posedge clock) disable iff (reset)
      cmd.store |-> $past(cmd.setup && sts.bypass) || $past(sts.div_done))
      else $error("store without a quotient or bypass value");

endmodule
